### hw/rtl/crc_be_pkg.sv
// shared constants and register codes for the bit-serial crc encoder and checker
`timescale 1ns / 1ps
package crc_be_pkg;

  // configuration field widths
  localparam int DegreeW = 6;
  localparam int PolyW   = 32;
  localparam int CfgIdxW = 1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_DEGREE   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_POLY_LOW = 1'd1;

  // register reset values
  localparam logic [DegreeW-1:0] DEGREE_RESET   = 6'd16;
  localparam logic [PolyW-1:0]   POLY_LOW_RESET = 32'h0000_1021;

  // operation codes of the func field
  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_CHECK  = 1'b1;

endpackage

### hw/rtl/crc_be_front.sv
// front end: configuration registers, division step per bit, work entry generation
`timescale 1ns / 1ps
module crc_be_front #(
  parameter int MAX_DEGREE = 32,
  parameter int DW = $clog2(MAX_DEGREE + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [crc_be_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [crc_be_pkg::PolyW-1:0]         cfg_data,
  input  logic                                 accept,
  input  logic                                 func,
  input  logic                                 data_bit,
  input  logic                                 last_bit,
  output logic                                 ent_push,
  output logic                                 ent_func,
  output logic                                 ent_bit,
  output logic                                 ent_last,
  output logic                                 ent_err,
  output logic [MAX_DEGREE-1:0]                ent_snap,
  output logic [DW-1:0]                        ent_deg
);

  localparam logic [crc_be_pkg::DegreeW:0] MaxDeg = (crc_be_pkg::DegreeW + 1)'(MAX_DEGREE);

  logic [crc_be_pkg::DegreeW-1:0] degree;
  logic [crc_be_pkg::PolyW-1:0]   poly_low;
  logic [MAX_DEGREE-1:0]          remainder;
  logic [MAX_DEGREE-1:0]          remainder_next;

  logic [DW-1:0]         deg_eff;
  logic [MAX_DEGREE-1:0] mask;
  logic [MAX_DEGREE-1:0] poly;
  logic [63:0]           poly64;
  logic [MAX_DEGREE-1:0] r_m;
  logic [MAX_DEGREE-1:0] r_new;
  logic                  top;
  logic [DW-1:0]         shamt;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      degree   <= crc_be_pkg::DEGREE_RESET;
      poly_low <= crc_be_pkg::POLY_LOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        crc_be_pkg::REG_DEGREE:   degree   <= cfg_data[crc_be_pkg::DegreeW-1:0];
        crc_be_pkg::REG_POLY_LOW: poly_low <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective degree, clamped to the supported range
  always_comb begin
    if (degree == '0) begin
      deg_eff = DW'(1);
    end else if ({1'b0, degree} > MaxDeg) begin
      deg_eff = DW'(MAX_DEGREE);
    end else begin
      deg_eff = DW'(degree);
    end
  end

  // degree mask and generator coefficients
  always_comb begin
    for (int k = 0; k < MAX_DEGREE; k++) begin
      mask[k] = (k < int'(deg_eff));
    end
  end

  assign poly64 = {32'b0, poly_low};
  assign poly   = poly64[MAX_DEGREE-1:0] & mask;
  assign r_m    = remainder & mask;
  assign top    = |(r_m & (mask ^ (mask >> 1)));

  // one division step
  always_comb begin
    if (func == crc_be_pkg::FUNC_ENCODE) begin
      r_new = ((r_m << 1) & mask) ^ ((top ^ data_bit) ? poly : '0);
    end else begin
      r_new = (((r_m << 1) | MAX_DEGREE'(data_bit)) & mask) ^ (top ? poly : '0);
    end
  end

  assign remainder_next = last_bit ? '0 : r_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= remainder_next;
    end
  end

  // work entry: remainder left aligned so the back end shifts out from the top
  assign shamt    = DW'(MAX_DEGREE) - deg_eff;
  assign ent_push = accept && ((func == crc_be_pkg::FUNC_ENCODE) || last_bit);
  assign ent_func = func;
  assign ent_bit  = data_bit;
  assign ent_last = last_bit;
  assign ent_err  = |r_new;
  assign ent_snap = r_new << shamt;
  assign ent_deg  = deg_eff;

endmodule

### hw/rtl/crc_be_fifo.sv
// small register queue between the front and back ends
`timescale 1ns / 1ps
module crc_be_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

### hw/rtl/crc_be_back.sv
// back end: echoes bits, serializes the remainder, holds the output word
`timescale 1ns / 1ps
module crc_be_back #(
  parameter int MAX_DEGREE = 32,
  parameter int DW = $clog2(MAX_DEGREE + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ent_valid,
  output logic                  ent_pop,
  input  logic                  ent_func,
  input  logic                  ent_bit,
  input  logic                  ent_last,
  input  logic                  ent_err,
  input  logic [MAX_DEGREE-1:0] ent_snap,
  input  logic [DW-1:0]         ent_deg,
  output logic                  empty,
  input  logic                  pop,
  output logic                  out_bit,
  output logic                  out_last,
  output logic                  is_check,
  output logic                  error_flag
);

  logic                  out_valid;
  logic                  out_valid_next;
  logic                  out_bit_next;
  logic                  out_last_next;
  logic                  is_check_next;
  logic                  error_flag_next;
  logic [MAX_DEGREE-1:0] sr;
  logic [MAX_DEGREE-1:0] sr_next;
  logic [DW-1:0]         cnt;
  logic [DW-1:0]         cnt_next;
  logic                  can_load;

  assign empty    = !out_valid;
  assign can_load = !out_valid || pop;

  // next output word: remainder bits first, then the queue head
  always_comb begin
    out_valid_next  = out_valid;
    out_bit_next    = out_bit;
    out_last_next   = out_last;
    is_check_next   = is_check;
    error_flag_next = error_flag;
    sr_next         = sr;
    cnt_next        = cnt;
    ent_pop         = 1'b0;
    if (can_load) begin
      if (cnt != '0) begin
        out_valid_next  = 1'b1;
        out_bit_next    = sr[MAX_DEGREE-1];
        out_last_next   = (cnt == DW'(1));
        is_check_next   = 1'b1;
        error_flag_next = 1'b0;
        sr_next         = sr << 1;
        cnt_next        = cnt - DW'(1);
      end else if (ent_valid) begin
        ent_pop         = 1'b1;
        out_valid_next  = 1'b1;
        is_check_next   = 1'b0;
        if (ent_func == crc_be_pkg::FUNC_CHECK) begin
          out_bit_next    = 1'b0;
          out_last_next   = 1'b1;
          error_flag_next = ent_err;
        end else begin
          out_bit_next    = ent_bit;
          out_last_next   = 1'b0;
          error_flag_next = 1'b0;
          if (ent_last) begin
            sr_next  = ent_snap;
            cnt_next = ent_deg;
          end
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_bit    <= out_bit_next;
    out_last   <= out_last_next;
    is_check   <= is_check_next;
    error_flag <= error_flag_next;
    sr         <= sr_next;
  end

endmodule

### hw/rtl/crc_bit_serial_encode_check.sv
// top level of the bit-serial crc encoder and checker
// result entries are queued, then loaded into the output register when it is free
// throughput: one input word per cycle while full is low; an encode message end adds
//   degree remainder words, absorbed by the 4-entry front/back queue, then full is raised
// reset: synchronous rst clears the remainder, queue and output; degree 16, poly_low 0x1021
`timescale 1ns / 1ps
module crc_bit_serial_encode_check #(
  parameter int MAX_DEGREE = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crc_be_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [crc_be_pkg::PolyW-1:0]   cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic                           func,
  input  logic                           data_bit,
  input  logic                           last_bit,
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_bit,
  output logic                           out_last,
  output logic                           is_check,
  output logic                           error_flag
);

  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int EW = 4 + MAX_DEGREE + DW;

  logic                  accept;
  logic                  ent_push;
  logic                  f_func;
  logic                  f_bit;
  logic                  f_last;
  logic                  f_err;
  logic [MAX_DEGREE-1:0] f_snap;
  logic [DW-1:0]         f_deg;
  logic [EW-1:0]         wr_data;
  logic [EW-1:0]         rd_data;
  logic                  rd_valid;
  logic                  rd_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // front: config and division
  crc_be_front #(.MAX_DEGREE(MAX_DEGREE), .DW(DW)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .func      (func),
    .data_bit  (data_bit),
    .last_bit  (last_bit),
    .ent_push  (ent_push),
    .ent_func  (f_func),
    .ent_bit   (f_bit),
    .ent_last  (f_last),
    .ent_err   (f_err),
    .ent_snap  (f_snap),
    .ent_deg   (f_deg)
  );

  assign wr_data = {f_func, f_bit, f_last, f_err, f_snap, f_deg};

  // work queue
  crc_be_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (ent_push),
    .wr_data  (wr_data),
    .full     (full),
    .rd_en    (rd_pop),
    .rd_valid (rd_valid),
    .rd_data  (rd_data)
  );

  // back: output serializer
  crc_be_back #(.MAX_DEGREE(MAX_DEGREE), .DW(DW)) u_back (
    .clk        (clk),
    .rst        (rst),
    .ent_valid  (rd_valid),
    .ent_pop    (rd_pop),
    .ent_func   (rd_data[EW-1]),
    .ent_bit    (rd_data[EW-2]),
    .ent_last   (rd_data[EW-3]),
    .ent_err    (rd_data[EW-4]),
    .ent_snap   (rd_data[DW +: MAX_DEGREE]),
    .ent_deg    (rd_data[DW-1:0]),
    .empty      (empty),
    .pop        (pop),
    .out_bit    (out_bit),
    .out_last   (out_last),
    .is_check   (is_check),
    .error_flag (error_flag)
  );

endmodule

### verif/crc_be_scoreboard.sv
// scoreboard package for the bit-serial crc encoder and checker testbench
`timescale 1ns / 1ps
package crc_be_tb_pkg;
  import crc_be_pkg::*;

  localparam int MaxDegree = 32;

  // one output word of the block
  typedef struct packed {
    logic out_bit;
    logic out_last;
    logic is_check;
    logic error_flag;
  } crc_word_t;

  class crc_scoreboard;
    logic [DegreeW-1:0] degree;
    logic [PolyW-1:0]   poly_low;
    logic [63:0]        remainder;
    crc_word_t          expected_words[$];
    int                 errors;

    function new();
      degree    = DEGREE_RESET;
      poly_low  = POLY_LOW_RESET;
      remainder = '0;
      errors    = 0;
    endfunction

    // mirror of a register write
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [PolyW-1:0] data);
      if (idx == REG_DEGREE) begin
        degree = data[DegreeW-1:0];
      end else begin
        poly_low = data;
      end
    endfunction

    // degree clamped to the supported range
    function int unsigned eff_degree();
      int unsigned d;
      d = degree;
      if (d < 1) d = 1;
      if (d > MaxDegree) d = MaxDegree;
      return d;
    endfunction

    // divide one accepted bit and queue the words it produces
    function void note_input(logic f, logic b, logic last);
      int unsigned d;
      logic [63:0] mask;
      logic [63:0] poly;
      logic [63:0] r;
      logic        top;
      logic        fb;
      crc_word_t   w;
      d    = eff_degree();
      mask = (64'd1 << d) - 64'd1;
      poly = {32'd0, poly_low} & mask;
      r    = remainder & mask;
      top  = r[d-1];
      if (f == FUNC_ENCODE) begin
        // augmented division, message bit echoed
        fb = top ^ b;
        r  = (r << 1) & mask;
        if (fb) r = r ^ poly;
        w = {b, 1'b0, 1'b0, 1'b0};
        expected_words.push_back(w);
        if (last) begin
          for (int i = 0; i < d; i++) begin
            w = {r[d-1-i], (i == d - 1) ? 1'b1 : 1'b0, 1'b1, 1'b0};
            expected_words.push_back(w);
          end
          r = '0;
        end
      end else begin
        // plain division, one verdict word at the end
        r = ((r << 1) | {63'd0, b}) & mask;
        if (top) r = r ^ poly;
        if (last) begin
          w = {1'b0, 1'b1, 1'b0, (r != 0) ? 1'b1 : 1'b0};
          expected_words.push_back(w);
          r = '0;
        end
      end
      remainder = r & mask;
    endfunction

    // compare an output word with the oldest expected one
    function void check_word(crc_word_t got);
      crc_word_t want;
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_bit %0d out_last %0d is_check %0d error_flag %0d",
               got.out_bit, got.out_last, got.is_check, got.error_flag);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (got.out_bit !== want.out_bit) begin
        $error("out_bit mismatch: expected %0d, actual %0d", want.out_bit, got.out_bit);
        errors++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last mismatch: expected %0d, actual %0d", want.out_last, got.out_last);
        errors++;
      end
      if (got.is_check !== want.is_check) begin
        $error("is_check mismatch: expected %0d, actual %0d", want.is_check, got.is_check);
        errors++;
      end
      if (got.error_flag !== want.error_flag) begin
        $error("error_flag mismatch: expected %0d, actual %0d",
               want.error_flag, got.error_flag);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

### verif/testbench.sv
// top-level testbench for the bit-serial crc encoder and checker
`timescale 1ns / 1ps
module testbench;
  import crc_be_pkg::*;
  import crc_be_tb_pkg::*;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [PolyW-1:0]   cfg_data;
  logic               push;
  logic               full;
  logic               func;
  logic               data_bit;
  logic               last_bit;
  logic               empty;
  logic               pop;
  logic               out_bit;
  logic               out_last;
  logic               is_check;
  logic               error_flag;

  crc_scoreboard sb;
  logic          calm;
  logic          hold_req;
  int            words_sent;
  logic          msg_funcs[$];
  logic          msg_bits[$];

  crc_bit_serial_encode_check DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .func       (func),
    .data_bit   (data_bit),
    .last_bit   (last_bit),
    .empty      (empty),
    .pop        (pop),
    .out_bit    (out_bit),
    .out_last   (out_last),
    .is_check   (is_check),
    .error_flag (error_flag)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // output side: random pop, with a long hold-off on request
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (80) @(negedge clk);
        hold_req = 1'b0;
      end else if (calm) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 15);
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_word({out_bit, out_last, is_check, error_flag});
    end
  end

  // offer one input word until it is taken
  task automatic send_word(logic f, logic b, logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 15) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push     <= 1'b1;
    func     <= f;
    data_bit <= b;
    last_bit <= last;
    do @(posedge clk); while (full);
    sb.note_input(f, b, last);
    words_sent++;
  endtask

  // send the built message, last flag on its final word
  task automatic send_msg();
    for (int i = 0; i < msg_bits.size(); i++) begin
      send_word(msg_funcs[i], msg_bits[i], (i == msg_bits.size() - 1));
    end
    msg_funcs.delete();
    msg_bits.delete();
  endtask

  function automatic void add_bit(logic f, logic b);
    msg_funcs.push_back(f);
    msg_bits.push_back(b);
  endfunction

  // append the crc of the current message so it forms a valid codeword
  function automatic void add_check_bits();
    int unsigned d;
    logic [63:0] mask;
    logic [63:0] poly;
    logic [63:0] r;
    logic        fb;
    d    = sb.eff_degree();
    mask = (64'd1 << d) - 64'd1;
    poly = {32'd0, sb.poly_low} & mask;
    r    = '0;
    foreach (msg_bits[i]) begin
      fb = r[d-1] ^ msg_bits[i];
      r  = (r << 1) & mask;
      if (fb) r = r ^ poly;
    end
    for (int i = d - 1; i >= 0; i--) add_bit(FUNC_CHECK, r[i]);
  endfunction

  // stop offering and let every expected word drain
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [PolyW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random message: mostly well-formed, some corrupted or mixed-mode
  task automatic random_message();
    int unsigned d;
    int          kind;
    int          len;
    int          pos;
    d    = sb.eff_degree();
    kind = $urandom_range(99);
    if (kind < 35) begin
      len = $urandom_range(1, 12);
      repeat (len) add_bit(FUNC_ENCODE, 1'($urandom_range(1)));
    end else if (kind < 80) begin
      len = $urandom_range(1, 10);
      repeat (len) add_bit(FUNC_CHECK, 1'($urandom_range(1)));
      add_check_bits();
      if (kind >= 65) begin
        pos = $urandom_range(msg_bits.size() - 1);
        msg_bits[pos] = ~msg_bits[pos];
      end
    end else if (kind < 90) begin
      len = (d > 1) ? $urandom_range(1, d - 1) : 1;
      repeat (len) add_bit(FUNC_CHECK, 1'($urandom_range(1)));
    end else begin
      len = $urandom_range(1, 8);
      repeat (len) add_bit(1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    send_msg();
  endtask

  // reconfigure once idle, then run random messages
  task automatic run_phase(logic [DegreeW-1:0] deg, logic [PolyW-1:0] poly,
                           logic pressure);
    int target;
    wait_idle();
    write_cfg(REG_DEGREE, ($urandom & ~32'h3F) | {26'd0, deg});
    write_cfg(REG_POLY_LOW, poly);
    if (pressure) begin
      calm     = 1'b1;
      hold_req = 1'b1;
    end
    target = words_sent + 10;
    while (words_sent < target) random_message();
    calm = 1'b0;
  endtask

  // main sequence
  initial begin
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = REG_DEGREE;
    cfg_data   = '0;
    push       = 1'b0;
    func       = FUNC_ENCODE;
    data_bit   = 1'b0;
    last_bit   = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    words_sent = 0;
    sb         = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single-bit encode at the reset polynomial
    add_bit(FUNC_ENCODE, 1'b1);
    send_msg();
    // check of a message shorter than the degree
    add_bit(FUNC_CHECK, 1'b1);
    add_bit(FUNC_CHECK, 1'b0);
    add_bit(FUNC_CHECK, 1'b1);
    send_msg();
    // all-zero check, remainder stays clean
    add_bit(FUNC_CHECK, 1'b0);
    add_bit(FUNC_CHECK, 1'b0);
    send_msg();

    // small polynomial x^4 + x + 1
    wait_idle();
    write_cfg(REG_DEGREE, 32'd4);
    write_cfg(REG_POLY_LOW, 32'h3);
    add_bit(FUNC_ENCODE, 1'b1);
    add_bit(FUNC_ENCODE, 1'b0);
    add_bit(FUNC_ENCODE, 1'b1);
    add_bit(FUNC_ENCODE, 1'b1);
    send_msg();
    // matching codeword must pass
    add_bit(FUNC_CHECK, 1'b1);
    add_bit(FUNC_CHECK, 1'b0);
    add_bit(FUNC_CHECK, 1'b1);
    add_bit(FUNC_CHECK, 1'b1);
    add_check_bits();
    send_msg();
    // mode switched inside a message
    add_bit(FUNC_ENCODE, 1'b1);
    add_bit(FUNC_ENCODE, 1'b1);
    add_bit(FUNC_CHECK, 1'b0);
    add_bit(FUNC_CHECK, 1'b1);
    send_msg();

    // random phases across the degree range
    run_phase(6'd1, 32'h0000_0001, 1'b0);
    run_phase(6'd32, 32'h04C1_1DB7, 1'b1);
    run_phase(6'd0, $urandom, 1'b0);
    run_phase(6'd63, 32'hFFFF_FFFF, 1'b0);
    run_phase(6'd8, 32'h0000_0007, 1'b0);
    run_phase(6'd5, 32'h0000_0000, 1'b0);
    run_phase(6'($urandom_range(1, 32)), $urandom, 1'b0);

    // drain and finish
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/crc_be_pkg.sv
hw/rtl/crc_be_front.sv
hw/rtl/crc_be_fifo.sv
hw/rtl/crc_be_back.sv
hw/rtl/crc_bit_serial_encode_check.sv
verif/crc_be_scoreboard.sv
verif/testbench.sv
